// ===== design/huffman_triplet_rle_decoder_unit_macros.svh =====
// Assertion macros for the decoder top module.
`ifndef HUFFMAN_TRIPLET_RLE_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TRIPLET_RLE_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HTRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HTRD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HTRD_ASSERT(lbl, prop, msg)
`define HTRD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== design/htrd_pkg.sv =====
`timescale 1ns / 1ps
package htrd_pkg;

  localparam int BITMAP_BYTES = 6080;
  localparam int MARKER_DEPTH = 256;
  localparam int TREE_DEPTH   = 256;

  localparam int EXP_DEFAULT_I = BITMAP_BYTES;
  localparam int EXP_EARLY_I   = BITMAP_BYTES + 64 + 760;
  localparam int EXP_PLAIN_I   = BITMAP_BYTES + 380 + 760;
  localparam int EXP_WIDE_I    = BITMAP_BYTES + 760 + 760;
  localparam int EXP_MAX       = 8191;

  localparam logic [12:0] EXP_DEFAULT = (EXP_DEFAULT_I > EXP_MAX) ? 13'(EXP_MAX)
                                                                  : 13'(EXP_DEFAULT_I);
  localparam logic [12:0] EXP_EARLY   = (EXP_EARLY_I > EXP_MAX) ? 13'(EXP_MAX)
                                                                : 13'(EXP_EARLY_I);
  localparam logic [12:0] EXP_PLAIN   = (EXP_PLAIN_I > EXP_MAX) ? 13'(EXP_MAX)
                                                                : 13'(EXP_PLAIN_I);
  localparam logic [12:0] EXP_WIDE    = (EXP_WIDE_I > EXP_MAX) ? 13'(EXP_MAX)
                                                               : 13'(EXP_WIDE_I);

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_RUN    = 1'b1;

  typedef enum logic [3:0] {
    PH_WAIT = 4'b0001,
    PH_TREE = 4'b0010,
    PH_HEAD = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

  typedef logic [2:0][7:0] triple_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic [7:0] repeat_count;
    logic [3:0] colour_zero;
    logic [3:0] colour_three;
    logic       wide_colour_map;
    logic       picture_done;
    logic       last_of_item;
  } res_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic step;
    logic take;
  } walk_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic triple_done;
  } walk_stat_t;

  typedef struct packed {
    logic clear;
    logic header;
    logic lit;
    logic read;
    logic decide;
  } rle_cmd_t;

endpackage

// ===== design/htrd_channels.sv =====
`timescale 1ns / 1ps
interface htrd_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface htrd_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic [7:0] repeat_count;
  logic [3:0] colour_zero;
  logic [3:0] colour_three;
  logic       wide_colour_map;
  logic       picture_done;
  logic       last_of_item;
  modport source (output valid, output kind, output byte_value, output repeat_count,
                  output colour_zero, output colour_three, output wide_colour_map,
                  output picture_done, output last_of_item, input ready);
  modport sink (input valid, input kind, input byte_value, input repeat_count,
                input colour_zero, input colour_three, input wide_colour_map,
                input picture_done, input last_of_item, output ready);
endinterface

interface htrd_cfg_if;
  logic valid;
  logic ready;
  logic early_layout;
  modport source (output valid, output early_layout, input ready);
  modport sink (input valid, input early_layout, output ready);
endinterface

// ===== design/htrd_tree_walk.sv =====
`timescale 1ns / 1ps
module htrd_tree_walk (
  input  logic                  clk,
  input  logic                  rst,
  input  htrd_pkg::walk_cmd_t   cmd,
  input  logic [7:0]            data,
  output htrd_pkg::walk_stat_t  stat,
  output htrd_pkg::triple_t     triple
);
  import htrd_pkg::*;

  logic [7:0] tree_mem [TREE_DEPTH];
  logic [7:0] rd_data;
  logic [8:0] tree_pos;
  logic [7:0] bits;
  logic [3:0] bit_cnt;
  logic [6:0] node_index;
  logic [1:0] leaf_count;
  triple_t    tri_buf;

  always_ff @(posedge clk) begin
    if (cmd.load && !tree_pos[8]) begin
      tree_mem[tree_pos[7:0]] <= data;
    end
    // bit 1 takes the first byte of the pair, bit 0 the second
    if (cmd.step) begin
      rd_data <= tree_mem[{node_index, ~bits[7]}];
    end
    if (cmd.start) begin
      bits <= data;
    end else if (cmd.step) begin
      bits <= {bits[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_pos   <= '0;
      bit_cnt    <= '0;
      node_index <= '0;
      leaf_count <= '0;
      tri_buf    <= '0;
    end else begin
      if (cmd.clear) begin
        tree_pos   <= '0;
        node_index <= '0;
        leaf_count <= '0;
        tri_buf    <= '0;
      end
      if (cmd.load && !tree_pos[8]) begin
        tree_pos <= tree_pos + 9'd1;
      end
      if (cmd.start) begin
        bit_cnt <= 4'd8;
      end else if (cmd.step) begin
        bit_cnt <= bit_cnt - 4'd1;
      end
      if (cmd.take) begin
        if (rd_data[7]) begin
          node_index <= rd_data[6:0];
        end else begin
          node_index <= '0;
          if (leaf_count != 2'd3) begin
            tri_buf[leaf_count] <= rd_data;
            leaf_count <= leaf_count + 2'd1;
          end else begin
            // spread the fourth leaf over the top bits of the three before it
            tri_buf[0] <= tri_buf[0] | {rd_data[5:4], 6'b0};
            tri_buf[1] <= tri_buf[1] | {rd_data[3:2], 6'b0};
            tri_buf[2] <= tri_buf[2] | {rd_data[1:0], 6'b0};
            leaf_count <= '0;
          end
        end
      end
    end
  end

  assign stat.bits_done   = (bit_cnt == 4'd0);
  assign stat.triple_done = cmd.take && !rd_data[7] && (leaf_count == 2'd3);
  assign triple           = tri_buf;

endmodule

// ===== design/htrd_rle.sv =====
`timescale 1ns / 1ps
module htrd_rle (
  input  logic               clk,
  input  logic               rst,
  input  htrd_pkg::rle_cmd_t cmd,
  input  logic [7:0]         value,
  input  htrd_pkg::triple_t  triple,
  input  logic               early_layout,
  output htrd_pkg::res_t     res,
  output logic               res_valid,
  output logic               full
);
  import htrd_pkg::*;

  // value -> highest marker slot holding it
  logic [7:0]   rev_mem [256];
  logic [255:0] rev_valid;
  logic [7:0]   rev_q;
  logic         hit_q;

  logic [7:0]  last_literal;
  logic [12:0] bytes_written;
  logic [12:0] bytes_expected;
  logic [7:0]  marker_fill;
  logic [7:0]  marker_total;

  logic        store;
  logic        slot_ok;
  logic [7:0]  rep;
  logic        run_go;
  logic [7:0]  run_val;
  logic [7:0]  want;
  logic [12:0] room;
  logic [7:0]  cnt;
  logic [12:0] written_new;
  logic        emit;

  always_comb begin
    store   = marker_fill < marker_total;
    slot_ok = {1'b0, marker_fill} < 9'(MARKER_DEPTH);
    rep     = hit_q ? rev_q + 8'd1 : 8'd0;
    run_go  = cmd.lit || (cmd.decide && !store);
    if (cmd.lit) begin
      run_val = triple[2];
      want    = 8'd1;
    end else if (rep != 8'd0) begin
      run_val = last_literal;
      want    = rep;
    end else begin
      run_val = value;
      want    = 8'd1;
    end
    room        = (bytes_written < bytes_expected) ? bytes_expected - bytes_written : '0;
    cnt         = ({5'b0, want} < room) ? want : room[7:0];
    written_new = bytes_written + {5'b0, cnt};
    emit        = run_go && (cnt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rev_q <= rev_mem[value];
    end
    if (cmd.decide && store && slot_ok) begin
      rev_mem[value] <= marker_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rev_valid      <= '0;
      hit_q          <= 1'b0;
      last_literal   <= '0;
      bytes_written  <= '0;
      bytes_expected <= EXP_DEFAULT;
      marker_fill    <= '0;
      marker_total   <= '0;
    end else begin
      if (cmd.read) begin
        hit_q <= rev_valid[value];
      end
      if (cmd.clear) begin
        last_literal   <= '0;
        bytes_written  <= '0;
        bytes_expected <= EXP_DEFAULT;
        marker_fill    <= '0;
        marker_total   <= '0;
      end
      if (cmd.header) begin
        rev_valid     <= '0;
        bytes_written <= '0;
        marker_fill   <= '0;
        if (early_layout) begin
          marker_total   <= triple[2];
          bytes_expected <= EXP_EARLY;
        end else if (triple[0] == 8'd0) begin
          marker_total   <= '0;
          bytes_expected <= EXP_PLAIN;
        end else begin
          marker_total   <= triple[2];
          bytes_expected <= EXP_WIDE;
        end
      end
      if (cmd.decide && store) begin
        if (slot_ok) begin
          rev_valid[value] <= 1'b1;
        end
        marker_fill <= marker_fill + 8'd1;
      end
      if (cmd.lit) begin
        last_literal <= triple[2];
      end else if (cmd.decide && !store && rep == 8'd0 && bytes_written < bytes_expected) begin
        last_literal <= value;
      end
      if (emit) begin
        bytes_written <= written_new;
      end
    end
  end

  always_comb begin
    res = '0;
    if (cmd.header) begin
      res.kind = KIND_HEADER;
      if (early_layout) begin
        res.colour_zero  = triple[0][3:0];
        res.colour_three = triple[1][3:0];
      end else if (triple[0] != 8'd0) begin
        res.colour_zero     = triple[1][3:0];
        res.colour_three    = triple[1][3:0];
        res.wide_colour_map = 1'b1;
      end
    end else begin
      res.kind         = KIND_RUN;
      res.byte_value   = run_val;
      res.repeat_count = cnt;
      res.picture_done = written_new >= bytes_expected;
    end
  end

  assign res_valid = cmd.header || emit;
  assign full      = bytes_written >= bytes_expected;

endmodule

// ===== design/huffman_triplet_rle_decoder_unit.sv =====
`timescale 1ns / 1ps
// Decoder for tree-coded, triple-packed, run-length compressed pictures.
// items carries one stream byte per beat; first_byte marks the tree size byte
// that starts a picture. results carries header and run beats, with
// last_of_item set on the final beat caused by one input byte. cfg writes the
// early_layout register and is always ready; write it while the block idles.
// A size byte, a tree byte or a byte before the first start is taken in the
// idle state alone, so such bytes can follow back to back. A coded byte is
// accepted, then each bit is one read of the tree memory with registered
// data (a bit step, then a node step). A last bit step sees the end of the
// bits and a close step ends the byte; each value of a finished triple adds
// a marker lookup memory read, then a decision, and the header adds a header
// step and, for the plain layout, a literal step. A byte finishes at most
// two triples. Once the picture total is reached a byte passes only accept,
// one bit check and close. Results pass through a holding register and an
// output register, so a stalled receiver stops the walk only when both are
// full; the next byte is accepted as soon as the last result of the current
// one is in the output register. Reset returns to waiting for a first byte;
// the tree and marker memories are not cleared and need no clearing pass.
`include "huffman_triplet_rle_decoder_unit_macros.svh"
module huffman_triplet_rle_decoder_unit (
  input  logic           clk,
  input  logic           rst,
  htrd_item_if.sink      items,
  htrd_result_if.source  results,
  htrd_cfg_if.sink       cfg
);
  import htrd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BIT   = 7'b0000010,
    ST_NODE  = 7'b0000100,
    ST_HDR   = 7'b0001000,
    ST_HLIT  = 7'b0010000,
    ST_RD    = 7'b0100000,
    ST_DEC   = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic        flushing, flushing_next;
  phase_t      phase, phase_next;
  logic [9:0]  tree_bytes_left, tree_bytes_left_next;
  logic [1:0]  elem, elem_next;
  logic        early_layout;

  walk_cmd_t   wcmd;
  walk_stat_t  wstat;
  triple_t     triple;
  rle_cmd_t    rcmd;
  res_t        rle_res;
  logic        rle_valid;
  logic        full;

  res_t        out_q;
  logic        out_valid;
  res_t        pend_q;
  logic        pend_valid;
  logic        stall;
  logic        flush_move;
  logic        accept;
  logic [8:0]  size_p1;

  htrd_tree_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .cmd    (wcmd),
    .data   (items.data_byte),
    .stat   (wstat),
    .triple (triple)
  );

  htrd_rle u_rle (
    .clk          (clk),
    .rst          (rst),
    .cmd          (rcmd),
    .value        (triple[elem]),
    .triple       (triple),
    .early_layout (early_layout),
    .res          (rle_res),
    .res_valid    (rle_valid),
    .full         (full)
  );

  assign items.ready = (state == ST_IDLE) && !flushing;
  assign accept      = items.valid && items.ready;
  assign cfg.ready   = 1'b1;
  assign stall       = pend_valid && out_valid && !results.ready;
  assign flush_move  = flushing && pend_valid && !(out_valid && !results.ready);
  assign size_p1     = {1'b0, items.data_byte} + 9'd1;

  always_comb begin
    state_next           = state;
    flushing_next        = flushing;
    phase_next           = phase;
    tree_bytes_left_next = tree_bytes_left;
    elem_next            = elem;
    wcmd                 = '0;
    rcmd                 = '0;
    if (flushing) begin
      // hand the held beat on as the last of its byte
      if (!pend_valid || flush_move) begin
        flushing_next = 1'b0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (items.first_byte) begin
              wcmd.clear           = 1'b1;
              rcmd.clear           = 1'b1;
              phase_next           = PH_TREE;
              tree_bytes_left_next = {size_p1, 1'b0};
            end else if (phase == PH_TREE) begin
              wcmd.load = 1'b1;
              if (tree_bytes_left > 10'd1) begin
                tree_bytes_left_next = tree_bytes_left - 10'd1;
              end else begin
                tree_bytes_left_next = '0;
                phase_next           = PH_HEAD;
              end
            end else if (phase == PH_HEAD || phase == PH_BODY) begin
              wcmd.start = 1'b1;
              state_next = ST_BIT;
            end
          end
        end
        ST_BIT: begin
          if (wstat.bits_done || (phase == PH_BODY && full)) begin
            state_next    = ST_IDLE;
            flushing_next = 1'b1;
          end else begin
            wcmd.step  = 1'b1;
            state_next = ST_NODE;
          end
        end
        ST_NODE: begin
          wcmd.take = 1'b1;
          if (wstat.triple_done) begin
            elem_next  = '0;
            state_next = (phase == PH_HEAD) ? ST_HDR : ST_RD;
          end else begin
            state_next = ST_BIT;
          end
        end
        ST_HDR: begin
          if (!stall) begin
            rcmd.header = 1'b1;
            phase_next  = PH_BODY;
            state_next  = (!early_layout && triple[0] == 8'd0) ? ST_HLIT : ST_BIT;
          end
        end
        ST_HLIT: begin
          if (!stall) begin
            rcmd.lit   = 1'b1;
            state_next = ST_BIT;
          end
        end
        ST_RD: begin
          rcmd.read  = 1'b1;
          state_next = ST_DEC;
        end
        ST_DEC: begin
          if (!stall) begin
            rcmd.decide = 1'b1;
            if (elem == 2'd2) begin
              state_next = ST_BIT;
            end else begin
              elem_next  = elem + 2'd1;
              state_next = ST_RD;
            end
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      flushing        <= 1'b0;
      phase           <= PH_WAIT;
      tree_bytes_left <= '0;
      elem            <= '0;
      early_layout    <= 1'b0;
      out_valid       <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      state           <= state_next;
      flushing        <= flushing_next;
      phase           <= phase_next;
      tree_bytes_left <= tree_bytes_left_next;
      elem            <= elem_next;
      if (cfg.valid) begin
        early_layout <= cfg.early_layout;
      end
      if ((rle_valid && pend_valid) || flush_move) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (rle_valid) begin
        pend_valid <= 1'b1;
      end else if (flush_move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rle_valid && pend_valid) begin
      out_q <= pend_q;
    end else if (flush_move) begin
      out_q              <= pend_q;
      out_q.last_of_item <= 1'b1;
    end
    if (rle_valid) begin
      pend_q <= rle_res;
    end
  end

  assign results.valid           = out_valid;
  assign results.kind            = out_q.kind;
  assign results.byte_value      = out_q.byte_value;
  assign results.repeat_count    = out_q.repeat_count;
  assign results.colour_zero     = out_q.colour_zero;
  assign results.colour_three    = out_q.colour_three;
  assign results.wide_colour_map = out_q.wide_colour_map;
  assign results.picture_done    = out_q.picture_done;
  assign results.last_of_item    = out_q.last_of_item;

  `HTRD_ASSERT(a_idle_no_pend, items.ready |-> !pend_valid, "byte accepted with result held")
  `HTRD_ASSERT(a_hdr_phase, (rle_valid && rle_res.kind == KIND_HEADER) |-> phase == PH_HEAD,
               "header result outside header phase")
  `HTRD_ASSERT(a_triple_node, wstat.triple_done |-> state == ST_NODE,
               "triple finished outside node step")
  `HTRD_ASSERT_NEXT(a_flush_last, flush_move, out_valid && out_q.last_of_item,
                    "closing beat lost its last mark")

endmodule

// ===== sim/huffman_triplet_rle_decoder_unit_test.sv =====
`timescale 1ns / 1ps
module huffman_triplet_rle_decoder_unit_test;
  import htrd_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 120;
  localparam int BIG_NODES = 40;

  typedef enum int {ROW_NONE, ROW_ONE, ROW_PRED} row_mode_t;
  typedef struct {
    bit        first;
    bit [7:0]  data;
    row_mode_t mode;
    res_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  htrd_item_if   items_ch ();
  htrd_result_if results_ch ();
  htrd_cfg_if    cfg_ch ();

  huffman_triplet_rle_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch),
    .cfg(cfg_ch)
  );

  always #4 clk = ~clk;

  // decoder image used to predict the run and header beats
  bit          early_sel;
  logic [7:0]  tree_mem [TREE_DEPTH];
  int          tree_left, tree_pos;
  logic [6:0]  walk_node;
  int          leaf_cnt;
  logic [7:0]  triple [3];
  logic [7:0]  marker_mem [MARKER_DEPTH];
  int          marker_fill, marker_total;
  logic [7:0]  last_lit;
  int          bytes_out, bytes_goal;
  phase_t      phase;

  res_t beat_q[$];
  res_t byte_beats[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  items_sent = 0;

  stim_row_t dir_rows [15] = '{
    '{1'b0, 8'h5a, ROW_NONE, '0},
    '{1'b1, 8'h00, ROW_NONE, '0},
    '{1'b0, 8'h01, ROW_NONE, '0},
    '{1'b0, 8'h00, ROW_NONE, '0},
    '{1'b0, 8'hff, ROW_ONE,
      '{KIND_HEADER, 8'h00, 8'h00, 4'h1, 4'h1, 1'b1, 1'b0, 1'b1}},
    '{1'b0, 8'h00, ROW_PRED, '0},
    '{1'b1, 8'h00, ROW_NONE, '0},
    '{1'b0, 8'h7f, ROW_NONE, '0},
    '{1'b0, 8'h00, ROW_NONE, '0},
    '{1'b0, 8'h00, ROW_PRED, '0},
    '{1'b0, 8'hff, ROW_PRED, '0},
    '{1'b0, 8'h0f, ROW_PRED, '0},
    '{1'b0, 8'hf0, ROW_PRED, '0},
    '{1'b0, 8'haa, ROW_PRED, '0},
    '{1'b0, 8'h55, ROW_PRED, '0}
  };

  function automatic void add_beat(res_t r);
    if (byte_beats.size() < 7) byte_beats.push_back(r);
  endfunction

  function automatic void add_run(logic [7:0] val, int want);
    int room;
    int cnt;
    res_t r;
    room = (bytes_out < bytes_goal) ? bytes_goal - bytes_out : 0;
    cnt = (want < room) ? want : room;
    if (cnt == 0) return;
    bytes_out += cnt;
    r = '0;
    r.kind = KIND_RUN;
    r.byte_value = val;
    r.repeat_count = cnt[7:0];
    r.picture_done = (bytes_out >= bytes_goal);
    add_beat(r);
  endfunction

  function automatic void take_header();
    res_t r;
    r = '0;
    r.kind = KIND_HEADER;
    phase = PH_BODY;
    bytes_out = 0;
    marker_fill = 0;
    if (early_sel) begin
      marker_total = triple[2];
      bytes_goal = EXP_EARLY;
      r.colour_zero = triple[0][3:0];
      r.colour_three = triple[1][3:0];
      add_beat(r);
    end else if (triple[0] == 8'h00) begin
      marker_total = 0;
      bytes_goal = EXP_PLAIN;
      add_beat(r);
      last_lit = triple[2];
      add_run(triple[2], 1);
    end else begin
      marker_total = triple[2];
      bytes_goal = EXP_WIDE;
      r.colour_zero = triple[1][3:0];
      r.colour_three = triple[1][3:0];
      r.wide_colour_map = 1'b1;
      add_beat(r);
    end
  endfunction

  function automatic void take_body();
    logic [7:0] v;
    int rep;
    for (int i = 0; i < 3; i++) begin
      v = triple[i];
      if (marker_fill < marker_total) begin
        if (marker_fill < MARKER_DEPTH) marker_mem[marker_fill] = v;
        marker_fill++;
      end else begin
        rep = 0;
        for (int j = 0; j < marker_fill && j < MARKER_DEPTH; j++)
          if (marker_mem[j] == v) rep = j + 1;
        if (rep != 0) begin
          add_run(last_lit, rep);
        end else if (bytes_out < bytes_goal) begin
          last_lit = v;
          add_run(v, 1);
        end
      end
    end
  endfunction

  // fills byte_beats with what one accepted byte produces
  function automatic void decode_byte(bit first, logic [7:0] v);
    logic [7:0] idx;
    logic [7:0] br;
    int w;
    byte_beats.delete();
    if (first) begin
      tree_left = 2 * (v + 1);
      tree_pos = 0;
      walk_node = '0;
      leaf_cnt = 0;
      triple = '{8'h00, 8'h00, 8'h00};
      marker_fill = 0;
      marker_total = 0;
      last_lit = 8'h00;
      bytes_out = 0;
      bytes_goal = EXP_DEFAULT;
      phase = PH_TREE;
      return;
    end
    if (phase == PH_WAIT) return;
    if (phase == PH_TREE) begin
      if (tree_pos < TREE_DEPTH) tree_mem[tree_pos] = v;
      tree_pos++;
      if (tree_left > 0) tree_left--;
      if (tree_left == 0) phase = PH_HEAD;
      return;
    end
    for (int b = 7; b >= 0; b--) begin
      if (phase == PH_BODY && bytes_out >= bytes_goal) break;
      idx = {walk_node, ~v[b]};
      br = tree_mem[idx];
      if (br[7]) begin
        walk_node = br[6:0];
        continue;
      end
      walk_node = '0;
      if (leaf_cnt < 3) begin
        triple[leaf_cnt] = br;
        leaf_cnt++;
      end else begin
        leaf_cnt = 0;
        w = br;
        for (int k = 0; k < 3; k++) begin
          triple[k] = triple[k] | 8'((w << 2) & 8'hc0);
          w = (w << 2) & 8'hff;
        end
        if (phase == PH_HEAD) take_header();
        else take_body();
      end
    end
    if (byte_beats.size() > 0) byte_beats[byte_beats.size() - 1].last_of_item = 1'b1;
  endfunction

  // valid stays high after the accepting edge; the next beat or an idle cycle replaces it
  task automatic send_byte(bit first, logic [7:0] v, row_mode_t mode, res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.first_byte <= first;
    items_ch.data_byte <= v;
    do @(posedge clk); while (!items_ch.ready);
    items_sent++;
    decode_byte(first, v);
    if (mode == ROW_PRED) begin
      foreach (byte_beats[i]) beat_q.push_back(byte_beats[i]);
    end else if (mode == ROW_ONE) begin
      beat_q.push_back(want);
    end
  endtask

  task automatic push_byte(bit first, logic [7:0] v);
    send_byte(first, v, ROW_PRED, '0);
  endtask

  task automatic write_layout(bit val);
    items_ch.valid <= 1'b0;
    wait (beat_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.early_layout <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    early_sel = val;
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed pictures; some cut short inside the tree, some noise
  task automatic random_picture(int body_len);
    int n;
    int tree_len;
    n = ($urandom_range(9) == 0) ? $urandom_range(8, BIG_NODES) : $urandom_range(0, 6);
    tree_len = 2 * (n + 1);
    if ($urandom_range(9) == 0) tree_len = $urandom_range(1, tree_len);
    push_byte(1'b1, n[7:0]);
    for (int i = 0; i < tree_len; i++) begin
      if ($urandom_range(2) == 0) push_byte(1'b0, 8'h80 | 8'($urandom_range(0, n)));
      else push_byte(1'b0, 8'($urandom_range(0, 127)));
    end
    for (int i = 0; i < body_len; i++) begin
      if ($urandom_range(3) == 0) push_byte(1'b0, 8'($urandom_range(0, 7)));
      else push_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      random_picture($urandom_range(4, 20));
    end
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) begin
        if (beat_q.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %p", $time,
                   {results_ch.kind, results_ch.byte_value, results_ch.repeat_count});
          fail_count++;
        end else begin
          res_t e;
          e = beat_q.pop_front();
          check_field("kind", e.kind, results_ch.kind);
          check_field("byte_value", e.byte_value, results_ch.byte_value);
          check_field("repeat_count", e.repeat_count, results_ch.repeat_count);
          check_field("colour_zero", e.colour_zero, results_ch.colour_zero);
          check_field("colour_three", e.colour_three, results_ch.colour_three);
          check_field("wide_colour_map", e.wide_colour_map, results_ch.wide_colour_map);
          check_field("picture_done", e.picture_done, results_ch.picture_done);
          check_field("last_of_item", e.last_of_item, results_ch.last_of_item);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL huffman_triplet_rle_decoder_unit");
      $finish;
    end
  end

  initial begin
    items_ch.valid = 1'b0;
    items_ch.data_byte = '0;
    items_ch.first_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.early_layout = 1'b0;
    early_sel = 1'b0;
    phase = PH_WAIT;
    tree_left = 0;
    tree_pos = 0;
    walk_node = '0;
    leaf_cnt = 0;
    triple = '{8'h00, 8'h00, 8'h00};
    marker_fill = 0;
    marker_total = 0;
    last_lit = 8'h00;
    bytes_out = 0;
    bytes_goal = EXP_DEFAULT;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_layout(1'b0);
    foreach (dir_rows[i]) send_byte(dir_rows[i].first, dir_rows[i].data,
                                    dir_rows[i].mode, dir_rows[i].want);
    // full tree of the largest random size, so later short trees only reach
    // entries that were written here
    push_byte(1'b1, 8'(BIG_NODES));
    for (int i = 0; i < 2 * (BIG_NODES + 1); i++) begin
      if ($urandom_range(2) == 0) push_byte(1'b0, 8'h80 | 8'($urandom_range(0, BIG_NODES)));
      else push_byte(1'b0, 8'($urandom_range(0, 127)));
    end
    for (int i = 0; i < 6; i++) push_byte(1'b0, 8'($urandom_range(0, 255)));

    send_idle_pct = 59;
    write_layout(1'b1);
    random_phase(30);

    send_idle_pct = 0;
    recv_stall_pct = 59;
    write_layout(1'b0);
    hold_off = 400;
    random_phase(30);

    send_idle_pct = 35;
    recv_stall_pct = 35;
    write_layout(1'b1);
    random_phase(30);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_layout(1'b0);
    random_phase(30);

    items_ch.valid <= 1'b0;
    wait (beat_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS huffman_triplet_rle_decoder_unit");
    end else begin
      $display("FAIL huffman_triplet_rle_decoder_unit");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/htrd_pkg.sv
design/htrd_channels.sv
design/htrd_tree_walk.sv
design/htrd_rle.sv
design/huffman_triplet_rle_decoder_unit.sv
sim/huffman_triplet_rle_decoder_unit_test.sv
